/* rtl/tmp_pkg.sv */
`timescale 1ns / 1ps

package tmp_pkg;

  // Field and datapath widths
  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int SPD_W   = 24;
  localparam int MAG_W   = 33;            // |goal - pos| and distance
  localparam int SUM_W   = 66;            // sum of three squares
  localparam int PROD_W  = 66;            // shared multiplier result
  localparam int DNUM_W  = 57;            // divider numerator / quotient
  localparam int DCNT_W  = 6;
  localparam int IN_W    = 240;
  localparam int OUT_W   = 120;
  localparam int CFG_A_W = 2;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_LIN_VMAX   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_LIN_ACCEL  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_MAX_TURN   = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_TURN_ACCEL = 2'd3;

  localparam logic [SPD_W-1:0] RST_LIN_VMAX   = 24'd153600;
  localparam logic [SPD_W-1:0] RST_LIN_ACCEL  = 24'd256000;
  localparam logic [SPD_W-1:0] RST_MAX_TURN   = 24'd4194304;
  localparam logic [SPD_W-1:0] RST_TURN_ACCEL = 24'd8388608;

  // Datapath operation codes
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_LOAD       = 5'd1;
  localparam op_t OP_ABS        = 5'd2;
  localparam op_t OP_SQX        = 5'd3;
  localparam op_t OP_SQY        = 5'd4;
  localparam op_t OP_SQZ        = 5'd5;
  localparam op_t OP_SQS        = 5'd6;
  localparam op_t OP_SQRT_GO    = 5'd7;
  localparam op_t OP_SPD_LOAD   = 5'd8;
  localparam op_t OP_BRK_A      = 5'd9;
  localparam op_t OP_BRK_B      = 5'd10;
  localparam op_t OP_BRK_C      = 5'd11;
  localparam op_t OP_TGT_GO     = 5'd12;
  localparam op_t OP_TGT        = 5'd13;
  localparam op_t OP_MAG_GO     = 5'd14;
  localparam op_t OP_MAG        = 5'd15;
  localparam op_t OP_STEP_MUL   = 5'd16;
  localparam op_t OP_STEP_APPLY = 5'd17;
  localparam op_t OP_LEN_MUL    = 5'd18;
  localparam op_t OP_LEN        = 5'd19;
  localparam op_t OP_AX_MUL     = 5'd20;
  localparam op_t OP_AX_GO      = 5'd21;
  localparam op_t OP_AX_UPD     = 5'd22;
  localparam op_t OP_YAW_MUL    = 5'd23;
  localparam op_t OP_YAW        = 5'd24;
  localparam op_t OP_FIN        = 5'd25;

  typedef struct packed {
    op_t        op;
    logic       sel;     // 0: linear profile, 1: yaw profile
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic brake;
    logic dist_zero;
  } status_t;

endpackage

/* rtl/tmp_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The numerator arrives
// left-aligned so that only its significant bits are iterated.
module tmp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tmp_pkg::DNUM_W-1:0]  num,
  input  logic [tmp_pkg::DCNT_W-1:0]  nbits,
  input  logic [tmp_pkg::MAG_W-1:0]   den,
  output logic [tmp_pkg::DNUM_W-1:0]  quo,
  output logic                        done
);

  logic [tmp_pkg::DNUM_W-1:0] num_r;
  logic [tmp_pkg::DNUM_W-1:0] quo_r;
  logic [tmp_pkg::MAG_W-1:0]  den_r;
  logic [tmp_pkg::MAG_W-1:0]  rem_r;
  logic [tmp_pkg::DCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [tmp_pkg::MAG_W:0]    trial;
  logic                       fit;

  assign trial = {rem_r, num_r[tmp_pkg::DNUM_W-1]};
  assign fit   = (trial >= {1'b0, den_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[tmp_pkg::DNUM_W-2:0], 1'b0};
      rem_r <= fit ? tmp_pkg::MAG_W'(trial - {1'b0, den_r})
                   : trial[tmp_pkg::MAG_W-1:0];
      quo_r <= {quo_r[tmp_pkg::DNUM_W-2:0], fit};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

/* rtl/tmp_sqrt.sv */
`timescale 1ns / 1ps

// Digit-by-digit integer square root, one root bit per cycle.
module tmp_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tmp_pkg::SUM_W-1:0]  rad,
  output logic [tmp_pkg::MAG_W-1:0]  root,
  output logic                       done
);

  localparam int REM_W = tmp_pkg::MAG_W + 2;

  logic [tmp_pkg::SUM_W-1:0] rad_r;
  logic [REM_W-1:0]          rem_r;
  logic [tmp_pkg::MAG_W-1:0] root_r;
  logic [tmp_pkg::DCNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [REM_W+1:0]          rem2;
  logic [REM_W+1:0]          trial;
  logic                      fit;

  assign rem2  = {rem_r, rad_r[tmp_pkg::SUM_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign fit   = (rem2 >= trial);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= tmp_pkg::DCNT_W'(tmp_pkg::MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Two radicand bits per step
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[tmp_pkg::SUM_W-3:0], 2'b00};
      rem_r  <= fit ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
      root_r <= {root_r[tmp_pkg::MAG_W-2:0], fit};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* rtl/tmp_ctrl.sv */
`timescale 1ns / 1ps

// Sequencer: walks the datapath through one tick and owns both handshakes.
module tmp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  tmp_pkg::status_t stat,
  output tmp_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ABS      = 5'd1;
  localparam logic [4:0] S_SQX      = 5'd2;
  localparam logic [4:0] S_SQY      = 5'd3;
  localparam logic [4:0] S_SQZ      = 5'd4;
  localparam logic [4:0] S_SQS      = 5'd5;
  localparam logic [4:0] S_SQRT_GO  = 5'd6;
  localparam logic [4:0] S_SQRT_WT  = 5'd7;
  localparam logic [4:0] S_SPD_LOAD = 5'd8;
  localparam logic [4:0] S_BRK_A    = 5'd9;
  localparam logic [4:0] S_BRK_B    = 5'd10;
  localparam logic [4:0] S_BRK_C    = 5'd11;
  localparam logic [4:0] S_BRK_DEC  = 5'd12;
  localparam logic [4:0] S_TGT_GO   = 5'd13;
  localparam logic [4:0] S_TGT_WT   = 5'd14;
  localparam logic [4:0] S_TGT      = 5'd15;
  localparam logic [4:0] S_MAG_GO   = 5'd16;
  localparam logic [4:0] S_MAG_WT   = 5'd17;
  localparam logic [4:0] S_MAG      = 5'd18;
  localparam logic [4:0] S_STEP_MUL = 5'd19;
  localparam logic [4:0] S_STEP     = 5'd20;
  localparam logic [4:0] S_LEN_MUL  = 5'd21;
  localparam logic [4:0] S_LEN      = 5'd22;
  localparam logic [4:0] S_AX_MUL   = 5'd23;
  localparam logic [4:0] S_AX_GO    = 5'd24;
  localparam logic [4:0] S_AX_WT    = 5'd25;
  localparam logic [4:0] S_AX_UPD   = 5'd26;
  localparam logic [4:0] S_YAW_MUL  = 5'd27;
  localparam logic [4:0] S_YAW      = 5'd28;
  localparam logic [4:0] S_FIN      = 5'd29;

  logic [4:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state and command
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    ax_nxt        = ax_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = tmp_pkg::OP_NONE;
    cmd.sel       = sel_r;
    cmd.axis      = ax_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = tmp_pkg::OP_LOAD;
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        cmd.op    = tmp_pkg::OP_ABS;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.op    = tmp_pkg::OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = tmp_pkg::OP_SQY;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        cmd.op    = tmp_pkg::OP_SQZ;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op    = tmp_pkg::OP_SQS;
        state_nxt = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd.op    = tmp_pkg::OP_SQRT_GO;
        state_nxt = S_SQRT_WT;
      end
      S_SQRT_WT: begin
        if (stat.sqrt_done) begin
          sel_nxt   = 1'b0;
          state_nxt = S_SPD_LOAD;
        end
      end
      S_SPD_LOAD: begin
        cmd.op    = tmp_pkg::OP_SPD_LOAD;
        state_nxt = S_BRK_A;
      end
      S_BRK_A: begin
        cmd.op    = tmp_pkg::OP_BRK_A;
        state_nxt = S_BRK_B;
      end
      S_BRK_B: begin
        cmd.op    = tmp_pkg::OP_BRK_B;
        state_nxt = S_BRK_C;
      end
      S_BRK_C: begin
        cmd.op    = tmp_pkg::OP_BRK_C;
        state_nxt = S_BRK_DEC;
      end
      S_BRK_DEC: begin
        state_nxt = stat.brake ? S_STEP_MUL : S_TGT_GO;
      end
      S_TGT_GO: begin
        cmd.op    = tmp_pkg::OP_TGT_GO;
        state_nxt = S_TGT_WT;
      end
      S_TGT_WT: begin
        if (stat.div_done) begin
          state_nxt = S_TGT;
        end
      end
      S_TGT: begin
        cmd.op    = tmp_pkg::OP_TGT;
        state_nxt = S_MAG_GO;
      end
      S_MAG_GO: begin
        cmd.op    = tmp_pkg::OP_MAG_GO;
        state_nxt = S_MAG_WT;
      end
      S_MAG_WT: begin
        if (stat.div_done) begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op    = tmp_pkg::OP_MAG;
        state_nxt = S_STEP_MUL;
      end
      S_STEP_MUL: begin
        cmd.op    = tmp_pkg::OP_STEP_MUL;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.op    = tmp_pkg::OP_STEP_APPLY;
        state_nxt = sel_r ? S_YAW_MUL : S_LEN_MUL;
      end
      S_LEN_MUL: begin
        cmd.op    = tmp_pkg::OP_LEN_MUL;
        state_nxt = S_LEN;
      end
      S_LEN: begin
        cmd.op = tmp_pkg::OP_LEN;
        ax_nxt = 2'd0;
        if (stat.dist_zero) begin
          sel_nxt   = 1'b1;
          state_nxt = S_SPD_LOAD;
        end else begin
          state_nxt = S_AX_MUL;
        end
      end
      S_AX_MUL: begin
        cmd.op    = tmp_pkg::OP_AX_MUL;
        state_nxt = S_AX_GO;
      end
      S_AX_GO: begin
        cmd.op    = tmp_pkg::OP_AX_GO;
        state_nxt = S_AX_WT;
      end
      S_AX_WT: begin
        if (stat.div_done) begin
          state_nxt = S_AX_UPD;
        end
      end
      S_AX_UPD: begin
        cmd.op = tmp_pkg::OP_AX_UPD;
        if (ax_r == 2'd2) begin
          sel_nxt   = 1'b1;
          state_nxt = S_SPD_LOAD;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_AX_MUL;
        end
      end
      S_YAW_MUL: begin
        cmd.op    = tmp_pkg::OP_YAW_MUL;
        state_nxt = S_YAW;
      end
      S_YAW: begin
        cmd.op    = tmp_pkg::OP_YAW;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Wait here until the output register is free
        if (out_free) begin
          cmd.op        = tmp_pkg::OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      ax_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/tmp_dp.sv */
`timescale 1ns / 1ps

// Datapath: captured word, shared multiplier, speed profile arithmetic,
// divider and square-root units, kept speeds and configuration registers.
module tmp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmp_pkg::cmd_t                 cmd,
  output tmp_pkg::status_t              stat,
  input  logic [tmp_pkg::IN_W-1:0]      in_word,
  input  logic                          cfg_we,
  input  logic [tmp_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [tmp_pkg::SPD_W-1:0]     cfg_wdata,
  output logic [tmp_pkg::OUT_W-1:0]     out_word
);

  // Configuration and kept speeds
  logic [tmp_pkg::SPD_W-1:0] lin_vmax_r, lin_accel_r, max_turn_r, turn_accel_r;
  logic [tmp_pkg::SPD_W-1:0] lin_speed_r, turn_rate_r;

  // Captured word
  logic [tmp_pkg::POS_W-1:0] pos_r  [3];
  logic [tmp_pkg::POS_W-1:0] goal_r [3];
  logic [tmp_pkg::ANG_W-1:0] hd_r, gh_r, dt_r;

  // Working registers
  logic [tmp_pkg::MAG_W-1:0]  m_r [3];
  logic [2:0]                 dneg_r;
  logic                       yneg_r;
  logic [tmp_pkg::ANG_W-1:0]  amag_r;
  logic [tmp_pkg::PROD_W-1:0] prod_r;
  logic [tmp_pkg::SUM_W-1:0]  sum_r;
  logic [tmp_pkg::MAG_W-1:0]  dist_r;
  logic [tmp_pkg::SPD_W-1:0]  v_r, vmax_r, a_r, diff_r, mag_r, ns_r, len_r;
  logic [tmp_pkg::MAG_W-1:0]  d_r;
  logic [57:0]                brk_r;
  logic                       brake_r, up_r;
  logic [tmp_pkg::POS_W-1:0]  npos_r [3];
  logic [tmp_pkg::ANG_W-1:0]  nh_r;

  // Output register
  logic [tmp_pkg::POS_W-1:0]  ox_r, oy_r, oz_r;
  logic [tmp_pkg::ANG_W-1:0]  oh_r;
  logic                       omoved_r, oturned_r;

  // Shared multiplier operands
  logic [tmp_pkg::MAG_W-1:0]  mul_a, mul_b;
  logic                       mul_en;

  // Units
  logic                       div_start, div_done;
  logic [tmp_pkg::DNUM_W-1:0] div_num, div_quo;
  logic [tmp_pkg::DCNT_W-1:0] div_cnt;
  logic [tmp_pkg::MAG_W-1:0]  div_den;
  logic                       sqrt_done;
  logic [tmp_pkg::MAG_W-1:0]  sqrt_root;

  // Per-step combinational values
  logic [tmp_pkg::POS_W:0]    dlt [3];
  logic [tmp_pkg::ANG_W-1:0]  yerr;
  logic [tmp_pkg::SPD_W-1:0]  tgt, qclip, step;
  logic [tmp_pkg::SPD_W:0]    vup;
  logic [tmp_pkg::SPD_W-1:0]  vnew;
  logic [tmp_pkg::POS_W+1:0]  p_ext, ax_sum;
  logic [tmp_pkg::POS_W-1:0]  ax_sat;
  logic [tmp_pkg::ANG_W-1:0]  yaw_step;

  // Signed differences goal - pos
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlt[k] = {goal_r[k][tmp_pkg::POS_W-1], goal_r[k]}
             - {pos_r[k][tmp_pkg::POS_W-1], pos_r[k]};
    end
  end
  assign yerr = gh_r - hd_r;

  // Multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      tmp_pkg::OP_SQX: begin
        mul_a = m_r[0];
        mul_b = m_r[0];
      end
      tmp_pkg::OP_SQY: begin
        mul_a = m_r[1];
        mul_b = m_r[1];
      end
      tmp_pkg::OP_SQZ: begin
        mul_a = m_r[2];
        mul_b = m_r[2];
      end
      tmp_pkg::OP_BRK_A: begin
        mul_a = d_r;
        mul_b = tmp_pkg::MAG_W'({a_r, 1'b0});
      end
      tmp_pkg::OP_BRK_B: begin
        mul_a = tmp_pkg::MAG_W'(v_r);
        mul_b = tmp_pkg::MAG_W'(v_r);
      end
      tmp_pkg::OP_STEP_MUL: begin
        mul_a = tmp_pkg::MAG_W'(mag_r);
        mul_b = tmp_pkg::MAG_W'(dt_r);
      end
      tmp_pkg::OP_LEN_MUL, tmp_pkg::OP_YAW_MUL: begin
        mul_a = tmp_pkg::MAG_W'(ns_r);
        mul_b = tmp_pkg::MAG_W'(dt_r);
      end
      tmp_pkg::OP_AX_MUL: begin
        mul_a = m_r[cmd.axis];
        mul_b = tmp_pkg::MAG_W'(len_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Divider operand selection; numerators are left-aligned to DNUM_W bits
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_cnt   = '0;
    div_den   = tmp_pkg::MAG_W'(dt_r);
    case (cmd.op)
      tmp_pkg::OP_TGT_GO: begin
        div_start = 1'b1;
        div_num   = {d_r, 24'd0};
        div_cnt   = 6'd49;
      end
      tmp_pkg::OP_MAG_GO: begin
        div_start = 1'b1;
        div_num   = {diff_r, 33'd0};
        div_cnt   = 6'd40;
      end
      tmp_pkg::OP_AX_GO: begin
        div_start = 1'b1;
        div_num   = prod_r[tmp_pkg::DNUM_W-1:0];
        div_cnt   = 6'd57;
        div_den   = dist_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  tmp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .nbits (div_cnt),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  tmp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == tmp_pkg::OP_SQRT_GO),
    .rad   (sum_r),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

  // Target speed and speed update arithmetic
  always_comb begin
    qclip = (div_quo > tmp_pkg::DNUM_W'(vmax_r)) ? vmax_r : div_quo[tmp_pkg::SPD_W-1:0];
    tgt   = qclip;
    step  = prod_r[39:16];
    vup   = {1'b0, v_r} + {1'b0, step};
    if (up_r) begin
      vnew = (vup > {1'b0, vmax_r}) ? vmax_r : vup[tmp_pkg::SPD_W-1:0];
    end else begin
      vnew = (step >= v_r) ? '0 : v_r - step;
      if (vnew > vmax_r) begin
        vnew = vmax_r;
      end
    end
  end

  // Axis move with saturation
  always_comb begin
    p_ext  = {{2{pos_r[cmd.axis][tmp_pkg::POS_W-1]}}, pos_r[cmd.axis]};
    ax_sum = dneg_r[cmd.axis] ? p_ext - {10'd0, div_quo[tmp_pkg::SPD_W-1:0]}
                              : p_ext + {10'd0, div_quo[tmp_pkg::SPD_W-1:0]};
    if (ax_sum[33] && !(ax_sum[32] && ax_sum[31])) begin
      ax_sat = 32'h8000_0000;
    end else if (!ax_sum[33] && (ax_sum[32] || ax_sum[31])) begin
      ax_sat = 32'h7FFF_FFFF;
    end else begin
      ax_sat = ax_sum[tmp_pkg::POS_W-1:0];
    end
    yaw_step = prod_r[39:24];
  end

  // Configuration and kept speeds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_vmax_r   <= tmp_pkg::RST_LIN_VMAX;
      lin_accel_r  <= tmp_pkg::RST_LIN_ACCEL;
      max_turn_r   <= tmp_pkg::RST_MAX_TURN;
      turn_accel_r <= tmp_pkg::RST_TURN_ACCEL;
      lin_speed_r  <= '0;
      turn_rate_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          tmp_pkg::REG_LIN_VMAX:   lin_vmax_r   <= cfg_wdata;
          tmp_pkg::REG_LIN_ACCEL:  lin_accel_r  <= cfg_wdata;
          tmp_pkg::REG_MAX_TURN:   max_turn_r   <= cfg_wdata;
          tmp_pkg::REG_TURN_ACCEL: turn_accel_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.op == tmp_pkg::OP_LEN && dist_r != '0) begin
        lin_speed_r <= ns_r;
      end
      if (cmd.op == tmp_pkg::OP_YAW && amag_r != '0) begin
        turn_rate_r <= ns_r;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (sqrt_done) begin
      dist_r <= sqrt_root;
    end
    case (cmd.op)
      tmp_pkg::OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          pos_r[k]  <= in_word[32*k +: 32];
          goal_r[k] <= in_word[112 + 32*k +: 32];
        end
        hd_r <= in_word[111:96];
        gh_r <= in_word[223:208];
        dt_r <= (in_word[239:224] == '0) ? 16'd1 : in_word[239:224];
      end
      tmp_pkg::OP_ABS: begin
        for (int k = 0; k < 3; k++) begin
          dneg_r[k] <= dlt[k][tmp_pkg::POS_W];
          m_r[k]    <= dlt[k][tmp_pkg::POS_W] ? tmp_pkg::MAG_W'(-dlt[k]) : dlt[k];
        end
        yneg_r <= (yerr > 16'h8000);
        amag_r <= (yerr > 16'h8000) ? 16'(-yerr) : yerr;
      end
      tmp_pkg::OP_SQY: begin
        sum_r <= prod_r;
      end
      tmp_pkg::OP_SQZ, tmp_pkg::OP_SQS: begin
        sum_r <= sum_r + prod_r;
      end
      tmp_pkg::OP_SPD_LOAD: begin
        if (cmd.sel) begin
          v_r    <= turn_rate_r;
          d_r    <= tmp_pkg::MAG_W'({amag_r, 8'd0});
          vmax_r <= max_turn_r;
          a_r    <= (turn_accel_r == '0) ? 24'd1 : turn_accel_r;
        end else begin
          v_r    <= lin_speed_r;
          d_r    <= dist_r;
          vmax_r <= lin_vmax_r;
          a_r    <= (lin_accel_r == '0) ? 24'd1 : lin_accel_r;
        end
      end
      tmp_pkg::OP_BRK_B: begin
        brk_r <= prod_r[57:0];
      end
      tmp_pkg::OP_BRK_C: begin
        brake_r <= (brk_r <= prod_r[57:0]);
        if (brk_r <= prod_r[57:0]) begin
          mag_r <= a_r;
          up_r  <= 1'b0;
        end
      end
      tmp_pkg::OP_TGT: begin
        up_r   <= (tgt >= v_r);
        diff_r <= (tgt >= v_r) ? tgt - v_r : v_r - tgt;
      end
      tmp_pkg::OP_MAG: begin
        mag_r <= (div_quo > tmp_pkg::DNUM_W'(a_r)) ? a_r : div_quo[tmp_pkg::SPD_W-1:0];
      end
      tmp_pkg::OP_STEP_APPLY: begin
        ns_r <= vnew;
      end
      tmp_pkg::OP_LEN: begin
        len_r <= prod_r[39:16];
        for (int k = 0; k < 3; k++) begin
          npos_r[k] <= pos_r[k];
        end
      end
      tmp_pkg::OP_AX_UPD: begin
        npos_r[cmd.axis] <= ax_sat;
      end
      tmp_pkg::OP_YAW: begin
        if (amag_r == '0) begin
          nh_r <= hd_r;
        end else begin
          nh_r <= yneg_r ? hd_r - yaw_step : hd_r + yaw_step;
        end
      end
      tmp_pkg::OP_FIN: begin
        ox_r      <= npos_r[0];
        oy_r      <= npos_r[1];
        oz_r      <= npos_r[2];
        oh_r      <= nh_r;
        omoved_r  <= (dist_r != '0);
        oturned_r <= (amag_r != '0);
      end
      default: begin
      end
    endcase
  end

  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.brake     = brake_r;
  assign stat.dist_zero = (dist_r == '0);

  assign out_word = {6'd0, oturned_r, omoved_r, oh_r, oz_r, oy_r, ox_r};

endmodule

/* rtl/trapezoidal_motion_profiler.sv */
`timescale 1ns / 1ps

// Trapezoidal motion profiler: one control tick per input word.
// The input word carries the current position and yaw, the goal position
// and yaw, and the tick time; the output word carries the new position and
// yaw plus the moved and turned flags. Both channels handshake on
// tvalid and tready. Configuration registers are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while the block is
// idle, and the block itself does not enforce this. out_tvalid rises after
// a square root of 33 root bits, then per profile a brake decision followed,
// when not braking, by two bit-serial divisions, and, when the position
// moves, three more divisions of 57 quotient bits each. The divider produces
// one quotient bit per cycle. One word is worked on at a time; the next word
// is taken as soon as the previous result sits in the output register, even
// if the receiver has not taken it yet. When the receiver stalls, the result
// holds and the block stops before loading the following result. Reset
// restores the register defaults and clears both kept speeds; no word is
// pending after reset.
module trapezoidal_motion_profiler (
  input  logic                           clk,
  input  logic                           rst_n,
  // pos_x, pos_y, pos_z, heading, goal_x, goal_y, goal_z, goal_heading, tick_time
  input  logic [tmp_pkg::IN_W-1:0]       in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // next_x, next_y, next_z, next_heading, moved, turned, zero fill
  output logic [tmp_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [tmp_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [tmp_pkg::SPD_W-1:0]      cfg_wdata
);

  tmp_pkg::cmd_t    cmd;
  tmp_pkg::status_t stat;

  tmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tmp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_tdata)
  );

endmodule
